// File: rtl/swsfr_pkg.sv
// ---------------------------------------------------------------------------
// swsfr_pkg
// Types and constants shared by the single-wire sensor frame receiver files.
// ---------------------------------------------------------------------------
package swsfr_pkg;

   // request opcodes
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_RISE  = 2'd1,
      OP_FALL  = 2'd2,
      OP_TICK  = 2'd3
   } opcode_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_SUM     = 2'd1,
      ST_TIMEOUT     = 2'd2,
      ST_NOT_ALLOWED = 2'd3
   } status_type;

   // receiver phase, one-hot
   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_ACK    = 3'b010,
      PH_STREAM = 3'b100
   } phase_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_BIT_THRESHOLD = 2'd0;
   localparam csr_index_type REG_TIMEOUT_TICKS = 2'd1;

   // field widths
   localparam int EDGE_TIME_W   = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int THRESHOLD_W   = 16;
   localparam int TICK_W        = 8;
   localparam int BYTE_W        = 8;
   localparam int FRAME_WORD_W  = 40;

   // configuration reset values
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd214;
   localparam logic [TICK_W-1:0]      TIMEOUT_RESET   = 8'd3;
   localparam logic [TICK_W-1:0]      TICK_MAX        = 8'd255;

   typedef logic [BYTE_W-1:0] byte_type;

   // one result
   typedef struct packed {
      status_type status;
      byte_type   humidity_high;
      byte_type   humidity_low;
      byte_type   temperature_high;
      byte_type   temperature_low;
      byte_type   checksum_byte;
   } result_type;

endpackage

// File: rtl/swsfr_ifs.sv
// ---------------------------------------------------------------------------
// swsfr channel interfaces
// Valid/ready channels for requests, results and register writes.
// ---------------------------------------------------------------------------
interface swsfr_req_if;
   import swsfr_pkg::*;

   logic                   valid;
   logic                   ready;
   opcode_type             opcode;
   logic [EDGE_TIME_W-1:0] edge_time;

   modport source (output valid, output opcode, output edge_time, input ready);
   modport sink   (input valid, input opcode, input edge_time, output ready);
endinterface

interface swsfr_rsp_if;
   import swsfr_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   byte_type   humidity_high;
   byte_type   humidity_low;
   byte_type   temperature_high;
   byte_type   temperature_low;
   byte_type   checksum_byte;

   modport source (output valid, output status, output humidity_high,
                   output humidity_low, output temperature_high,
                   output temperature_low, output checksum_byte, input ready);
   modport sink   (input valid, input status, input humidity_high,
                   input humidity_low, input temperature_high,
                   input temperature_low, input checksum_byte, output ready);
endinterface

interface swsfr_csr_if;
   import swsfr_pkg::*;

   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/single_wire_sensor_frame_receiver_unit.sv
// ---------------------------------------------------------------------------
// single_wire_sensor_frame_receiver_unit
// Event-driven receiver for a one-wire humidity/temperature sensor frame:
// times high pulses, shifts in bits and reports the frame or an error.
// ---------------------------------------------------------------------------
// Flow: a request is held in the input register and processed there;
//   a response goes to the result register that drives rsp valid.
// Throughput: one request per cycle;
//   a result still waiting on rsp_ch.ready holds the input register.
// Reset: synchronous; returns to idle, clears the shift register to its
//   sentinel and reloads bit_threshold = 214 and timeout_ticks = 3.
module single_wire_sensor_frame_receiver_unit #(
   parameter int FRAME_BITS = 40,
   parameter int TIME_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   swsfr_req_if.sink   req_ch,
   swsfr_rsp_if.source rsp_ch,
   swsfr_csr_if.sink   csr_ch
);
   import swsfr_pkg::*;

   localparam int SHIFT_W = FRAME_BITS + 1;
   localparam int EXT_W   = (TIME_WIDTH > EDGE_TIME_W) ? TIME_WIDTH : EDGE_TIME_W;
   localparam int WORD_W  = (SHIFT_W > FRAME_WORD_W) ? SHIFT_W : FRAME_WORD_W;

   // configuration registers
   logic [THRESHOLD_W-1:0] threshold_ff;
   logic [TICK_W-1:0]      timeout_ff;

   // input register
   logic                   in_valid_ff, in_valid_in;
   opcode_type             in_opcode_ff;
   logic [EDGE_TIME_W-1:0] in_time_ff;

   // receiver state
   phase_type              phase_ff, phase_in;
   logic                   waiting_fall_ff, waiting_fall_in;
   logic [TIME_WIDTH-1:0]  rise_time_ff, rise_time_in;
   logic [SHIFT_W-1:0]     shift_ff, shift_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   // working signals
   logic                   advance;
   logic                   emit;
   logic [EXT_W-1:0]       time_ext;
   logic [TIME_WIDTH-1:0]  time_w;
   logic [TIME_WIDTH-1:0]  pulse_width;
   logic [SHIFT_W-1:0]     shifted;
   logic [WORD_W-1:0]      word_ext;
   logic [FRAME_WORD_W-1:0] frame;
   byte_type               byte_sum;
   logic [TICK_W-1:0]      tick_inc;

   // handshakes
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // edge time masked to the timer width
   assign time_ext    = EXT_W'(in_time_ff);
   assign time_w      = time_ext[TIME_WIDTH-1:0];
   assign pulse_width = time_w - rise_time_ff;

   // shift in the measured bit
   always_comb begin
      shifted = {shift_ff[SHIFT_W-2:0], 1'b0};
      if (EXT_W'(pulse_width) >= EXT_W'(threshold_ff)) begin
         shifted[0] = 1'b1;
      end
   end

   // frame bytes and checksum
   assign word_ext = WORD_W'(shifted);
   assign frame    = word_ext[FRAME_WORD_W-1:0];
   assign byte_sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];

   assign tick_inc = (tick_ff < TICK_MAX) ? tick_ff + 1'b1 : tick_ff;

   // state update for the held request
   always_comb begin
      phase_in        = phase_ff;
      waiting_fall_in = waiting_fall_ff;
      rise_time_in    = rise_time_ff;
      shift_in        = shift_ff;
      tick_in         = tick_ff;
      emit            = 1'b0;
      rsp_in          = '0;
      rsp_in.status   = ST_OK;
      if (advance) begin
         case (in_opcode_ff)
            OP_START: begin
               if (phase_ff != PH_IDLE) begin
                  emit          = 1'b1;
                  rsp_in.status = ST_NOT_ALLOWED;
               end else begin
                  shift_in        = SHIFT_W'(1);
                  waiting_fall_in = 1'b0;
                  tick_in         = '0;
                  phase_in        = PH_ACK;
               end
            end
            OP_RISE: begin
               if (phase_ff == PH_ACK) begin
                  phase_in        = PH_STREAM;
                  waiting_fall_in = 1'b0;
               end else if (phase_ff == PH_STREAM && !waiting_fall_ff) begin
                  rise_time_in    = time_w;
                  waiting_fall_in = 1'b1;
               end
            end
            OP_FALL: begin
               if (phase_ff == PH_STREAM && waiting_fall_ff) begin
                  waiting_fall_in = 1'b0;
                  shift_in        = shifted;
                  if (shifted[FRAME_BITS]) begin
                     emit                    = 1'b1;
                     rsp_in.status           = (byte_sum == frame[7:0]) ? ST_OK : ST_BAD_SUM;
                     rsp_in.humidity_high    = frame[39:32];
                     rsp_in.humidity_low     = frame[31:24];
                     rsp_in.temperature_high = frame[23:16];
                     rsp_in.temperature_low  = frame[15:8];
                     rsp_in.checksum_byte    = frame[7:0];
                     phase_in                = PH_IDLE;
                     shift_in                = SHIFT_W'(1);
                     tick_in                 = '0;
                  end
               end
            end
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  tick_in = tick_inc;
                  if (tick_inc >= timeout_ff) begin
                     emit            = 1'b1;
                     rsp_in.status   = ST_TIMEOUT;
                     phase_in        = PH_IDLE;
                     waiting_fall_in = 1'b0;
                     shift_in        = SHIFT_W'(1);
                     tick_in         = '0;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // valid flags
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         timeout_ff      <= TIMEOUT_RESET;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_IDLE;
         waiting_fall_ff <= 1'b0;
         rise_time_ff    <= '0;
         shift_ff        <= SHIFT_W'(1);
         tick_ff         <= '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == REG_BIT_THRESHOLD) begin
               threshold_ff <= csr_ch.data[THRESHOLD_W-1:0];
            end else if (csr_ch.index == REG_TIMEOUT_TICKS) begin
               timeout_ff <= csr_ch.data[TICK_W-1:0];
            end
         end
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         waiting_fall_ff <= waiting_fall_in;
         rise_time_ff    <= rise_time_in;
         shift_ff        <= shift_in;
         tick_ff         <= tick_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_opcode_ff <= req_ch.opcode;
         in_time_ff   <= req_ch.edge_time;
      end
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // result port
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_ff.status;
   assign rsp_ch.humidity_high    = rsp_ff.humidity_high;
   assign rsp_ch.humidity_low     = rsp_ff.humidity_low;
   assign rsp_ch.temperature_high = rsp_ff.temperature_high;
   assign rsp_ch.temperature_low  = rsp_ff.temperature_low;
   assign rsp_ch.checksum_byte    = rsp_ff.checksum_byte;

`ifndef ASSERT_OFF
   // reset leaves the pipe empty and the receiver idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_IDLE) && !in_valid_ff && !rsp_valid_ff)
      else $error("receiver not idle after reset");

   // a pulse is only timed while streaming
   a_wait_in_stream: assert property (@(posedge clock) disable iff (reset)
      waiting_fall_ff |-> (phase_ff == PH_STREAM))
      else $error("fall awaited outside stream phase");

   // tick count is cleared whenever the receiver is idle
   a_idle_ticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_ff == '0))
      else $error("tick count left over in idle");

   // the sentinel bit never gets lost
   a_sentinel: assert property (@(posedge clock) disable iff (reset)
      shift_ff != '0)
      else $error("shift register lost its sentinel");

   // a finished frame or timeout sends the receiver back to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && (rsp_in.status == ST_OK || rsp_in.status == ST_BAD_SUM
                           || rsp_in.status == ST_TIMEOUT))
      |=> (phase_ff == PH_IDLE))
      else $error("receiver busy after end of read");
`endif

endmodule
